FILE: src/cbnd_pkg.sv
// Shared constants, codes and types of the CAN boot node discovery block.
`default_nettype none

package cbnd_pkg;

  // Node list sizing
  localparam int MAX_NODE_COUNT = 16;
  localparam int IDX_W = (MAX_NODE_COUNT > 1) ? $clog2(MAX_NODE_COUNT) : 1;
  localparam int KEY_W = 8 + IDX_W;

  // Frame matching
  localparam logic [31:0] ID_MASK       = 32'h0000_07FF;
  localparam logic [31:0] BOOT_FRAME_ID = 32'h0000_0100;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_IVL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

  // Register reset values
  localparam logic [7:0]  OWN_ID_RST   = 8'd0;
  localparam logic [31:0] SEND_IVL_RST = 32'd100;
  localparam logic [31:0] TIMEOUT_RST  = 32'd2000;

  // Request codes
  typedef logic [1:0] req_t;
  localparam req_t REQ_UPDATE = 2'd0;
  localparam req_t REQ_START  = 2'd1;
  localparam req_t REQ_READ   = 2'd2;

  // Discovery phase
  typedef enum logic [1:0] {
    PH_INIT      = 2'd0,
    PH_BROADCAST = 2'd1,
    PH_LISTEN    = 2'd2,
    PH_COMPLETE  = 2'd3
  } phase_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEND_CHK,
    ST_TOUT_CHK,
    ST_DUP_RD,
    ST_DUP_CMP,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_EMIT,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

FILE: src/cbnd_ifs.sv
// Request and result channel interfaces of the CAN boot node discovery block.
`default_nettype none

interface cbnd_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] now_ms;
  logic        frame_valid;
  logic [31:0] frame_id;
  logic [3:0]  frame_len;
  logic [7:0]  frame_byte0;

  modport source (
    output valid, req_type, now_ms, frame_valid, frame_id, frame_len, frame_byte0,
    input  ready
  );
  modport sink (
    input  valid, req_type, now_ms, frame_valid, frame_id, frame_len, frame_byte0,
    output ready
  );
endinterface

interface cbnd_res_if;
  logic       valid;
  logic       ready;
  logic       send_boot;
  logic       boot_done;
  logic [1:0] phase;
  logic [6:0] node_count;
  logic [7:0] node_id;
  logic       last;

  modport source (
    output valid, send_boot, boot_done, phase, node_count, node_id, last,
    input  ready
  );
  modport sink (
    input  valid, send_boot, boot_done, phase, node_count, node_id, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/can_boot_node_discovery_core.sv
// Top level of the CAN boot node discovery block: sequencer, timer unit and node list.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+---------------------------------------------
//  cmd       | in  | valid / ready    | req_type, now_ms, frame_valid, frame_id, ...
//  res       | out | valid / ready    | send_boot, boot_done, phase, node_count, ...
//  cfg       | in  | cfg_we           | cfg_index, cfg_data
//
//  Start and status-only items go straight to the result; an update uses one elapsed-time
//  subtractor up to twice (send interval, then timeout), then scans the node RAM for duplicates.
//  A read gives n = count + 1 results: each result is one selection pass over the
//  single-port node RAM with a registered read.
//  cmd.ready is high only when the sequencer is idle; a full result register stalls it.
//  rst is synchronous; the node RAM needs no clearing, entries past count are unread.
`default_nettype none

module can_boot_node_discovery_core (
  input  logic                             clk,
  input  logic                             rst,
  cbnd_cmd_if.sink                         cmd,
  cbnd_res_if.source                       res,
  input  logic                             cfg_we,
  input  logic [cbnd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbnd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cbnd_pkg::*;

  localparam logic [IDX_W-1:0] CNT_LIMIT = IDX_W'(MAX_NODE_COUNT - 1);

  // Configuration registers
  logic [7:0]  own_id;
  logic [31:0] send_ivl;
  logic [31:0] tout_ms;

  // Discovery state
  state_t           state, state_next;
  phase_t           phase;
  logic [31:0]      start_time;
  logic [31:0]      last_send;
  logic             done_flag;
  logic [IDX_W-1:0] count;

  // Item working registers
  logic [31:0]      now_r;
  logic [7:0]       fb0_r;
  logic             frame_hit_r;
  logic             send_r;
  logic [IDX_W-1:0] scan;
  logic [IDX_W-1:0] emitted;
  logic [KEY_W-1:0] prev_key;
  logic             have_prev;
  logic [KEY_W-1:0] best_key;
  logic             best_valid;

  // Node RAM
  logic [7:0]       mem [MAX_NODE_COUNT];
  logic [7:0]       rdata;
  logic [IDX_W-1:0] raddr;
  logic             mem_we;

  // Result register
  logic       res_valid;
  logic       out_send;
  logic       out_done;
  logic [1:0] out_phase;
  logic [6:0] out_count;
  logic [7:0] out_id;
  logic       out_last;
  logic       can_load;

  // Shared timer unit and sort compare
  logic [31:0]      op_base;
  logic [31:0]      op_lim;
  logic [31:0]      elapsed;
  logic             reached;
  logic [7:0]       cur_val;
  logic [KEY_W-1:0] cur_key;
  logic             is_cand;
  logic             better;
  logic             frame_hit;

  assign can_load = !res_valid || res.ready;

  // Qualify a received boot frame at accept
  assign frame_hit = cmd.frame_valid
                  && ((cmd.frame_id & ID_MASK) == BOOT_FRAME_ID)
                  && (cmd.frame_len != 4'd0)
                  && (cmd.frame_byte0 != own_id);

  // Elapsed time against a limit, wrapping at 32 bits
  always_comb begin
    case (state)
      ST_TOUT_CHK: begin
        op_base = start_time;
        op_lim  = tout_ms;
      end
      default: begin
        op_base = last_send;
        op_lim  = send_ivl;
      end
    endcase
    elapsed = now_r - op_base;
    reached = (elapsed >= op_lim);
  end

  // Selection key: value, then position (own ID at position 0)
  assign cur_val = (scan == '0) ? own_id : rdata;
  assign cur_key = {cur_val, scan};
  assign is_cand = !have_prev || (cur_key > prev_key);
  assign better  = !best_valid || (cur_key < best_key);

  // Next state and RAM control
  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    raddr      = scan;
    mem_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          case (cmd.req_type)
            REQ_START: state_next = ST_RESULT;
            REQ_READ:  state_next = ST_SORT_RD;
            REQ_UPDATE: begin
              if (phase == PH_BROADCAST || phase == PH_LISTEN) state_next = ST_SEND_CHK;
              else state_next = ST_RESULT;
            end
            default: state_next = ST_RESULT;
          endcase
        end
      end
      ST_SEND_CHK: state_next = (phase == PH_BROADCAST) ? ST_RESULT : ST_TOUT_CHK;
      ST_TOUT_CHK: state_next = frame_hit_r ? ST_DUP_RD : ST_RESULT;
      ST_DUP_RD: begin
        if (scan == count) begin
          mem_we     = (count != CNT_LIMIT);
          state_next = ST_RESULT;
        end else begin
          state_next = ST_DUP_CMP;
        end
      end
      ST_DUP_CMP: state_next = (rdata == fb0_r) ? ST_RESULT : ST_DUP_RD;
      ST_SORT_RD: begin
        raddr      = (scan == '0) ? '0 : scan - 1'b1;
        state_next = ST_SORT_CMP;
      end
      ST_SORT_CMP: state_next = (scan == count) ? ST_EMIT : ST_SORT_RD;
      ST_EMIT: begin
        if (can_load) state_next = (emitted == count) ? ST_IDLE : ST_SORT_RD;
      end
      ST_RESULT: begin
        if (can_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Node RAM with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[count] <= fb0_r;
    rdata <= mem[raddr];
  end

  // Configuration and discovery state
  always_ff @(posedge clk) begin
    if (rst) begin
      own_id     <= OWN_ID_RST;
      send_ivl   <= SEND_IVL_RST;
      tout_ms    <= TIMEOUT_RST;
      phase      <= PH_INIT;
      start_time <= '0;
      last_send  <= '0;
      done_flag  <= 1'b0;
      count      <= '0;
      send_r     <= 1'b0;
      scan       <= '0;
      emitted    <= '0;
      have_prev  <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_ID:   own_id   <= cfg_data[7:0];
          CFG_SEND_IVL: send_ivl <= cfg_data;
          CFG_TIMEOUT:  tout_ms  <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            send_r     <= 1'b0;
            scan       <= '0;
            emitted    <= '0;
            have_prev  <= 1'b0;
            best_valid <= 1'b0;
            if (cmd.req_type == REQ_START) begin
              phase      <= PH_BROADCAST;
              start_time <= cmd.now_ms;
              last_send  <= '0;
            end
            if (cmd.req_type == REQ_UPDATE && phase == PH_COMPLETE) done_flag <= 1'b1;
          end
        end
        ST_SEND_CHK: begin
          if (reached) begin
            send_r    <= 1'b1;
            last_send <= now_r;
          end
          if (phase == PH_BROADCAST) phase <= PH_LISTEN;
        end
        ST_TOUT_CHK: begin
          if (reached) phase <= PH_COMPLETE;
        end
        ST_DUP_RD: begin
          if (mem_we) count <= count + 1'b1;
        end
        ST_DUP_CMP: scan <= scan + 1'b1;
        ST_SORT_CMP: begin
          if (is_cand && better) best_valid <= 1'b1;
          if (scan != count) scan <= scan + 1'b1;
        end
        ST_EMIT: begin
          if (can_load) begin
            have_prev  <= 1'b1;
            best_valid <= 1'b0;
            scan       <= '0;
            emitted    <= emitted + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Item payload latches and selection keys
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.valid) begin
      now_r       <= cmd.now_ms;
      fb0_r       <= cmd.frame_byte0;
      frame_hit_r <= frame_hit;
    end
    if (state == ST_SORT_CMP && is_cand && better) best_key <= cur_key;
    if (state == ST_EMIT && can_load) prev_key <= best_key;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (can_load && (state == ST_EMIT || state == ST_RESULT)) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && (state == ST_EMIT || state == ST_RESULT)) begin
      out_done  <= done_flag;
      out_phase <= phase;
      out_count <= 7'(count) + 7'd1;
      if (state == ST_EMIT) begin
        out_send <= 1'b0;
        out_id   <= best_key[KEY_W-1 -: 8];
        out_last <= (emitted == count);
      end else begin
        out_send <= send_r;
        out_id   <= 8'd0;
        out_last <= 1'b1;
      end
    end
  end

  assign res.valid      = res_valid;
  assign res.send_boot  = out_send;
  assign res.boot_done  = out_done;
  assign res.phase      = out_phase;
  assign res.node_count = out_count;
  assign res.node_id    = out_id;
  assign res.last       = out_last;

  // A selection pass always finds a next key
  a_emit_has_best: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> best_valid)
    else $error("readout pass found no next node");

  // Done only follows the complete phase
  a_done_from_complete: assert property (@(posedge clk) disable iff (rst)
    $rose(done_flag) |-> $past(phase) == PH_COMPLETE)
    else $error("done flag set outside complete phase");

  // Boot request only from an update result, never from a readout
  a_send_status_only: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.send_boot |->
      res.last && res.node_id == 8'd0
      && (res.phase == PH_LISTEN || res.phase == PH_COMPLETE))
    else $error("boot request on unexpected result");

  // The node list only grows
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    count >= $past(count))
    else $error("node count decreased");

endmodule

`default_nettype wire
